// ===== sv/modular_exponentiation_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Modular exponentiation unit assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define MEXP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mexp_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Operand width and derived widths shared by the exponentiation modules.
// ---------------------------------------------------------------------------
package mexp_pkg;

  localparam int OPERAND_WIDTH = 31;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);
  localparam int S_DATA_W = ((3 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_W = ((OPERAND_WIDTH + 7) / 8) * 8;

endpackage

// ===== sv/mexp_mulmod.sv =====
// ---------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a * b mod m by add-and-double, with a double phase and an add phase for each multiplier bit.
// ---------------------------------------------------------------------------
module mexp_mulmod import mexp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] prod
);

  logic                     busy;
  logic                     phase;
  logic [CNT_W-1:0]         cnt;
  logic [OPERAND_WIDTH-1:0] acc;
  logic [OPERAND_WIDTH-1:0] a_r;
  logic [OPERAND_WIDTH-1:0] m_r;
  logic [OPERAND_WIDTH-1:0] b_sh;

  logic [OPERAND_WIDTH-1:0] addend;
  logic [OPERAND_WIDTH:0]   trial;
  logic [OPERAND_WIDTH+1:0] diff;
  logic [OPERAND_WIDTH-1:0] acc_next;

  // Phase zero doubles the accumulator, phase one adds the multiplicand when
  // the current multiplier bit is set; both are followed by one conditional
  // subtraction of the modulus.
  always_comb begin
    addend   = (phase && b_sh[OPERAND_WIDTH-1]) ? a_r : '0;
    trial    = phase ? ({1'b0, acc} + {1'b0, addend}) : {acc, 1'b0};
    diff     = {1'b0, trial} - {2'b0, m_r};
    acc_next = diff[OPERAND_WIDTH+1] ? trial[OPERAND_WIDTH-1:0] : diff[OPERAND_WIDTH-1:0];
  end

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= !start && busy && phase && (cnt == '0);
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CNT_W'(OPERAND_WIDTH - 1);
        acc   <= '0;
        a_r   <= a;
        m_r   <= m;
        b_sh  <= b;
      end else if (busy) begin
        acc   <= acc_next;
        phase <= ~phase;
        if (phase) begin
          b_sh <= {b_sh[OPERAND_WIDTH-2:0], 1'b0};
          if (cnt == '0) begin
            busy <= 1'b0;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== sv/modular_exponentiation_unit.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation unit
// Square-and-multiply exponentiation built on two bit-serial multipliers.
// ---------------------------------------------------------------------------
// The slave channel takes one word holding base, exponent and modulus. The
// master channel returns one word per input: power_result in m_tdata and the
// bad_modulus flag in m_tuser.
// After acceptance the base is reduced by one multiplier pass, then each of
// the exponent bits runs a multiply and a square side by side on the two
// multipliers. A pass steps through the operand bits, doubling and then
// adding for each bit. A zero modulus skips both multipliers and goes
// straight to the finish state.
// One item is worked on at a time; s_tready is high only while the unit is
// idle. The result sits in an output register, so a new word is taken while
// the previous result waits for m_tready. If the receiver still holds off
// when the next result is finished, that result waits inside the unit.
// Reset clears the control state and drops m_tvalid; no result is lost
// otherwise.
// ---------------------------------------------------------------------------
module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // base, exponent, modulus, zero fill
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // power_result, zero fill
  output logic                m_tuser   // bad_modulus
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_LAUNCH = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         ecnt;
  logic [OPERAND_WIDTH-1:0] exp_sh;
  logic [OPERAND_WIDTH-1:0] m_r;
  logic [OPERAND_WIDTH-1:0] acc_r;
  logic [OPERAND_WIDTH-1:0] sq_r;
  logic                     bad_r;
  logic [OPERAND_WIDTH-1:0] res_r;
  logic                     out_bad;

  logic [OPERAND_WIDTH-1:0] in_base;
  logic [OPERAND_WIDTH-1:0] in_exp;
  logic [OPERAND_WIDTH-1:0] in_mod;
  logic [OPERAND_WIDTH-1:0] one_mod;
  logic                     s_acc;
  logic                     out_free;

  logic                     mul_start;
  logic                     sqr_start;
  logic [OPERAND_WIDTH-1:0] sqr_a;
  logic [OPERAND_WIDTH-1:0] sqr_b;
  logic [OPERAND_WIDTH-1:0] sqr_m;
  logic                     mul_done;
  logic                     sqr_done;
  logic [OPERAND_WIDTH-1:0] mul_p;
  logic [OPERAND_WIDTH-1:0] sqr_p;

  assign in_base  = s_tdata[OPERAND_WIDTH-1:0];
  assign in_exp   = s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
  assign in_mod   = s_tdata[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH];
  assign one_mod  = (in_mod == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
  assign s_tready = (state == ST_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // The squarer also reduces the base at the start, as base * (1 mod m).
  assign mul_start = (state == ST_LAUNCH);
  assign sqr_start = (state == ST_LAUNCH) || (s_acc && (in_mod != '0));
  assign sqr_a     = (state == ST_LAUNCH) ? sq_r : one_mod;
  assign sqr_b     = (state == ST_LAUNCH) ? sq_r : in_base;
  assign sqr_m     = (state == ST_LAUNCH) ? m_r : in_mod;

  mexp_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (acc_r),
    .b     (sq_r),
    .m     (m_r),
    .done  (mul_done),
    .prod  (mul_p)
  );

  mexp_mulmod u_sqr (
    .clk   (clk),
    .rst   (rst),
    .start (sqr_start),
    .a     (sqr_a),
    .b     (sqr_b),
    .m     (sqr_m),
    .done  (sqr_done),
    .prod  (sqr_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      ecnt     <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            exp_sh <= in_exp;
            m_r    <= in_mod;
            acc_r  <= one_mod;
            ecnt   <= CNT_W'(OPERAND_WIDTH - 1);
            if (in_mod == '0) begin
              bad_r <= 1'b1;
              res_r <= '0;
              state <= ST_FIN;
            end else begin
              bad_r <= 1'b0;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          if (sqr_done) begin
            sq_r  <= sqr_p;
            state <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (sqr_done) begin
            sq_r   <= sqr_p;
            exp_sh <= {1'b0, exp_sh[OPERAND_WIDTH-1:1]};
            if (exp_sh[0]) begin
              acc_r <= mul_p;
            end
            if (ecnt == '0) begin
              res_r <= exp_sh[0] ? mul_p : acc_r;
              state <= ST_FIN;
            end else begin
              ecnt  <= ecnt - 1'b1;
              state <= ST_LAUNCH;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_DATA_W'(res_r);
            out_bad  <= bad_r;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tuser = out_bad;

`include "modular_exponentiation_unit_macros.svh"

  `MEXP_ASSERT_IMP(a_lockstep, state == ST_WAIT, mul_done == sqr_done, "multipliers out of step")
  `MEXP_ASSERT_IMP(a_bad_zero, m_tvalid && m_tuser, m_tdata == '0, "error word carries nonzero result")
  `MEXP_ASSERT_IMP(a_reduced, state == ST_FIN && !bad_r, res_r < m_r, "result not reduced by modulus")
  `MEXP_ASSERT_NEXT(a_leave_idle, s_tvalid && s_tready, state != ST_IDLE, "accepted word left unit idle")

endmodule

// ===== tb/modular_exponentiation_unit_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modular exponentiation unit testbench
// Sends base, exponent and modulus words through the slave stream. A model of
// base to the exponent modulo modulus predicts each result. Every returned
// word is compared field by field with the oldest prediction. The sender
// works in bursts with random gaps, and the receiver stalls in runs of its
// own, some of them longer than a whole exponentiation.
// ---------------------------------------------------------------------------
module modular_exponentiation_unit_test;
  import mexp_pkg::*;

  typedef bit [OPERAND_WIDTH-1:0] operand_t;

  typedef struct packed {
    operand_t power_result;
    bit       bad_modulus;
  } power_word_t;

  localparam operand_t MAX_OPND = {OPERAND_WIDTH{1'b1}};
  localparam operand_t ALT_OPND = operand_t'(64'h5555_5555_5555_5555);

  class power_ledger;
    power_word_t pending_powers[$];
    int          failures;

    function new();
      failures = 0;
    endfunction

    function longint unsigned raise_mod(longint unsigned b, longint unsigned e,
                                        longint unsigned m);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % m;
      sq  = b % m;
      for (int i = 0; i < OPERAND_WIDTH; i++) begin
        if (((e >> i) & 1) != 0) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc;
    endfunction

    function void note_operands(operand_t b, operand_t e, operand_t m);
      power_word_t w;
      w.bad_modulus  = (m == 0);
      w.power_result = (m == 0) ? '0 : operand_t'(raise_mod(64'(b), 64'(e), 64'(m)));
      pending_powers.push_back(w);
    endfunction

    function void check_power(operand_t power_result, bit bad_modulus);
      power_word_t w;
      if (pending_powers.size() == 0) begin
        $error("result word with none expected: power_result %0d bad_modulus %0d",
               power_result, bad_modulus);
        failures++;
        return;
      end
      w = pending_powers.pop_front();
      if (power_result != w.power_result) begin
        $error("power_result expected %0d, actual %0d", w.power_result, power_result);
        failures++;
      end
      if (bad_modulus != w.bad_modulus) begin
        $error("bad_modulus expected %0d, actual %0d", w.bad_modulus, bad_modulus);
        failures++;
      end
    endfunction

    function int pending();
      return pending_powers.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;

  power_ledger ledger;
  bit          calm;
  int          burst_left;
  int          ready_hold;

  modular_exponentiation_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_operands(input operand_t b, input operand_t e, input operand_t m);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({m, e, b});
    do @(posedge clk); while (!s_tready);
    ledger.note_operands(b, e, m);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      if (!calm) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2500)) @(negedge clk);
        else repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  endtask

  function automatic operand_t random_operand();
    return operand_t'({$urandom, $urandom});
  endfunction

  task automatic send_random_operands();
    int       kind;
    operand_t b;
    operand_t e;
    operand_t m;
    kind = $urandom_range(0, 15);
    b = random_operand();
    e = random_operand();
    m = random_operand();
    case (kind)
      0: begin
        m = '0;
      end
      1: begin
        m = operand_t'($urandom_range(1, 3));
      end
      2: begin
        e = '0;
      end
      3: begin
        m = operand_t'($urandom_range(1, 1000));
      end
      4: begin
        e = operand_t'($urandom_range(1, 8));
      end
      5: begin
        b = MAX_OPND - operand_t'($urandom_range(0, 3));
        m = MAX_OPND - operand_t'($urandom_range(0, 3));
      end
      default: begin
      end
    endcase
    send_operands(b, e, m);
  endtask

  always @(negedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (m_tready) begin
      m_tready <= 1'b0;
      ready_hold = ($urandom_range(0, 255) == 0) ? $urandom_range(1500, 4500)
                                                 : $urandom_range(1, 40);
    end else begin
      m_tready <= 1'b1;
      ready_hold = $urandom_range(0, 80);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      ledger.check_power(m_tdata[OPERAND_WIDTH-1:0], m_tuser);
    end
  end

  initial begin
    #200_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    ledger     = new();
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    calm       = 1'b0;
    burst_left = 0;
    ready_hold = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_operands('0, '0, '0);
    send_operands(MAX_OPND, MAX_OPND, '0);
    send_operands(operand_t'(5), '0, operand_t'(1));
    send_operands('0, '0, MAX_OPND);
    send_operands(MAX_OPND, '0, operand_t'(7));
    send_operands('0, MAX_OPND, MAX_OPND);
    send_operands(MAX_OPND, MAX_OPND, MAX_OPND);
    send_operands(MAX_OPND, operand_t'(1), operand_t'(1000));
    send_operands(MAX_OPND - operand_t'(1), operand_t'(2), MAX_OPND);
    send_operands(operand_t'(1), MAX_OPND, operand_t'(2));
    send_operands(operand_t'(3), MAX_OPND, MAX_OPND - operand_t'(1));
    send_operands(operand_t'(2), operand_t'(OPERAND_WIDTH - 1), MAX_OPND);
    send_operands(ALT_OPND, ~ALT_OPND, ALT_OPND);
    send_operands(~ALT_OPND, ALT_OPND, ~ALT_OPND);
    send_operands(MAX_OPND, operand_t'(1), operand_t'(2));
    send_operands(operand_t'(12345), operand_t'(65537), operand_t'(1));
    send_operands(operand_t'(2), operand_t'(1), operand_t'(3));
    send_operands(operand_t'(7), operand_t'(2), MAX_OPND);

    for (int i = 0; i < 272; i++) begin
      calm = (i >= 90 && i < 150);
      send_random_operands();
    end
    calm = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
